@@ hdl/assert_macros.svh @@
// Assertion macros shared by the sampler RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tbs_pkg.sv @@
// Shared types and constants for the terrain bilinear sampler.
// No dependencies; used by tbs_axis_map and terrain_bilinear_sampler.
package tbs_pkg;

  localparam int DATA_W     = 32;  // heights, world coordinates, register data
  localparam int DIFF_W     = 33;  // signed difference of two Q24.8 values
  localparam int PROD_W     = 66;  // signed product of two DIFF_W operands
  localparam int PROD_FRAC  = 24;  // fraction bits of Q24.8 times Q16.16
  localparam int CNT_W      = 9;   // grid_cols, grid_rows and cell coordinates
  localparam int CELL_IDX_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [DATA_W-1:0] INV_SPACING_RESET = 32'sd65536;
  localparam logic [DATA_W-1:0]        HEIGHT_BIAS       = 32'h8000_0000;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OUTSIDE = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_BAD_CFG = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_INV_SPACING_X = 3'd2,
    CFG_INV_SPACING_Y = 3'd3,
    CFG_GRID_COLS     = 3'd4,
    CFG_GRID_ROWS     = 3'd5
  } cfg_idx_t;

endpackage

@@ hdl/tbs_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; instanced by terrain_bilinear_sampler.
module tbs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hdl/tbs_axis_map.sv @@
// Splits one axis product (world offset times reciprocal spacing) into cell and fraction.
// Depends on tbs_pkg for the product and count widths.
module tbs_axis_map
  import tbs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [PROD_W-1:0] prod,
  input  logic [CNT_W-1:0]         count,
  output logic                     outside,
  output logic [CNT_W-1:0]         coord,
  output logic [FRAC_BITS-1:0]     frac
);

  localparam int SHIFT = PROD_FRAC - FRAC_BITS;

  logic [PROD_W-1:0] grid_pos;
  logic [PROD_W-1:0] limit;

  // The position is only meaningful when the product is non-negative.
  assign grid_pos = $unsigned(prod) >> SHIFT;
  assign limit    = PROD_W'(count - CNT_W'(1)) << FRAC_BITS;
  assign outside  = prod[PROD_W-1] || (grid_pos > limit);
  assign coord    = grid_pos[FRAC_BITS +: CNT_W];
  assign frac     = grid_pos[FRAC_BITS-1:0];

endmodule

@@ hdl/terrain_bilinear_sampler.sv @@
// Top level of the terrain bilinear sampler: grid store, mapping and blend sequencer.
// Depends on tbs_pkg, tbs_ram, tbs_axis_map and assert_macros.svh.
`include "assert_macros.svh"

// The block holds an elevation grid of MAX_COLS by MAX_ROWS cells, each a Q24.8
// height with a valid bit, in one single-port RAM. A transaction is accepted
// when start is high and busy is low. A write (func = 0) gives no result; a
// write to an index beyond the grid is dropped. A query (func = 1) gives
// exactly one result, shown on height and status while done is high for a
// single cycle; the receiver cannot hold it off, so it must take it in that
// cycle. A query that completes keeps busy high through the states MAPX, MAPY,
// CHKY, READ, WAITR and BL0 to BL4, and its result appears in the cycle in
// which busy falls, so a new transaction can be accepted alongside it. A query
// that fails on configuration or on range returns from CHKY, one that hits an
// invalid neighbour from WAITR. This sequence follows from one shared
// 33 by 33 bit multiplier, used in turn for both axis mappings and the three
// blends, and from the single RAM port, which reads the up to four neighbours
// one per cycle. After reset the block sweeps the RAM to clear every valid
// bit, one entry per cycle; busy is high throughout, but configuration
// writes are taken as usual. Configuration must only be written while busy
// is low.
module terrain_bilinear_sampler
  import tbs_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [CELL_IDX_W-1:0]    cell_index,
  input  logic signed [DATA_W-1:0] cell_height,
  input  logic                     cell_valid,
  input  logic signed [DATA_W-1:0] world_x,
  input  logic signed [DATA_W-1:0] world_y,
  // Result channel
  output logic                     done,
  output logic signed [DATA_W-1:0] height,
  output logic [1:0]               status,
  // Configuration port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RAM_W  = DATA_W + 1;

  // One-hot sequencer states.
  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_MAPX  = 12'b0000_0000_0100,
    ST_MAPY  = 12'b0000_0000_1000,
    ST_CHKY  = 12'b0000_0001_0000,
    ST_READ  = 12'b0000_0010_0000,
    ST_WAITR = 12'b0000_0100_0000,
    ST_BL0   = 12'b0000_1000_0000,
    ST_BL1   = 12'b0001_0000_0000,
    ST_BL2   = 12'b0010_0000_0000,
    ST_BL3   = 12'b0100_0000_0000,
    ST_BL4   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic signed [DATA_W-1:0] inv_spacing_x;
  logic signed [DATA_W-1:0] inv_spacing_y;
  logic [CNT_W-1:0]         grid_cols;
  logic [CNT_W-1:0]         grid_rows;

  // Query working registers.
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [PROD_W-1:0] prod;
  logic [CNT_W-1:0]         x0;
  logic [CNT_W-1:0]         y0;
  logic [FRAC_BITS-1:0]     fx;
  logic [FRAC_BITS-1:0]     fy;
  logic                     outx;
  logic [1:0]               slot;
  logic                     pend;
  logic [1:0]               pend_slot;
  logic                     fail;
  logic [DATA_W-1:0]        h [4];
  logic [DATA_W-1:0]        r0;
  logic [DATA_W-1:0]        r1;
  logic [AW-1:0]            clr_addr;

  // RAM port.
  logic                     ram_en;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [RAM_W-1:0]         ram_wdata;
  logic [RAM_W-1:0]         ram_rdata;

  // Shared multiplier.
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // Rounding adder.
  logic [DATA_W-1:0]        rnd_base;
  logic [PROD_W-1:0]        rnd_sum;
  logic [DATA_W-1:0]        rnd;

  // Axis mapping.
  logic [CNT_W-1:0]         ax_count;
  logic                     ax_out;
  logic [CNT_W-1:0]         ax_cell;
  logic [FRAC_BITS-1:0]     ax_frac;

  // Neighbour addressing.
  logic [CNT_W-1:0]         x1;
  logic [CNT_W-1:0]         y1;
  logic [CNT_W-1:0]         cx;
  logic [CNT_W-1:0]         cy;
  logic                     used;
  logic [AW-1:0]            rd_addr;

  logic                     accept;
  logic                     wr_accept;
  logic                     wr_in_range;
  logic [31:0]              idx_ext;
  logic                     bad_cfg;
  logic                     fail_now;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign wr_accept = accept && (func == FUNC_WRITE);

  // Writes beyond the grid are dropped.
  assign idx_ext     = 32'(cell_index);
  assign wr_in_range = idx_ext < 32'(DEPTH);

  // A configuration that cannot describe a grid fails every query.
  assign bad_cfg = (inv_spacing_x == '0) || (inv_spacing_y == '0) ||
                   (grid_cols == '0) || (grid_rows == '0) ||
                   (32'(grid_cols) > 32'(MAX_COLS)) ||
                   (32'(grid_rows) > 32'(MAX_ROWS));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_spacing_x <= INV_SPACING_RESET;
      inv_spacing_y <= INV_SPACING_RESET;
      grid_cols     <= '0;
      grid_rows     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:      origin_x      <= $signed(cfg_wdata);
        CFG_ORIGIN_Y:      origin_y      <= $signed(cfg_wdata);
        CFG_INV_SPACING_X: inv_spacing_x <= $signed(cfg_wdata);
        CFG_INV_SPACING_Y: inv_spacing_y <= $signed(cfg_wdata);
        CFG_GRID_COLS:     grid_cols     <= cfg_wdata[CNT_W-1:0];
        CFG_GRID_ROWS:     grid_rows     <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Axis mapping: the product register holds X after MAPX and Y after MAPY.
  // ---------------------------------------------------------------------------
  assign ax_count = (state == ST_MAPY) ? grid_cols : grid_rows;

  tbs_axis_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_map (
    .prod    (prod),
    .count   (ax_count),
    .outside (ax_out),
    .coord   (ax_cell),
    .frac    (ax_frac)
  );

  // ---------------------------------------------------------------------------
  // Neighbour addressing. The far neighbour is clamped to the last column or
  // row; at that edge the fraction is zero, so the clamped cell is skipped.
  // ---------------------------------------------------------------------------
  assign x1 = ((CNT_W + 1)'(x0) + (CNT_W + 1)'(1) < (CNT_W + 1)'(grid_cols)) ?
              x0 + CNT_W'(1) : x0;
  assign y1 = ((CNT_W + 1)'(y0) + (CNT_W + 1)'(1) < (CNT_W + 1)'(grid_rows)) ?
              y0 + CNT_W'(1) : y0;

  // Slot order: top-left, top-right, bottom-left, bottom-right.
  assign cx   = slot[0] ? x1 : x0;
  assign cy   = slot[1] ? y1 : y0;
  assign used = (!slot[0] || (fx != '0)) && (!slot[1] || (fy != '0));

  assign rd_addr = AW'(cy) * AW'(MAX_COLS) + AW'(cx);

  // A neighbour whose data lands this cycle also counts towards failure.
  assign fail_now = fail || (pend && !ram_rdata[DATA_W]);

  // ---------------------------------------------------------------------------
  // Grid RAM: height in the low bits, valid bit on top.
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_IDLE: begin
        ram_en    = wr_accept && wr_in_range;
        ram_we    = wr_accept && wr_in_range;
        ram_addr  = idx_ext[AW-1:0];
        ram_wdata = {cell_valid, cell_height};
      end
      ST_READ: begin
        ram_en = used;
      end
      default: begin
      end
    endcase
  end

  tbs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier. Mapping multiplies the world offset by the reciprocal
  // spacing; a blend a*(1-f) + b*f is formed as a*2^F + (b-a)*f.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = dx;
    mul_b = DIFF_W'(inv_spacing_x);
    unique case (state)
      ST_MAPY: begin
        mul_a = dy;
        mul_b = DIFF_W'(inv_spacing_y);
      end
      ST_BL0: begin
        mul_a = $signed({1'b0, h[1]}) - $signed({1'b0, h[0]});
        mul_b = $signed(DIFF_W'(fx));
      end
      ST_BL1: begin
        mul_a = $signed({1'b0, h[3]}) - $signed({1'b0, h[2]});
        mul_b = $signed(DIFF_W'(fx));
      end
      ST_BL3: begin
        mul_a = $signed({1'b0, r1}) - $signed({1'b0, r0});
        mul_b = $signed(DIFF_W'(fy));
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up; the blended value is never negative, so the sum is taken
  // modulo 2^PROD_W without loss.
  always_comb begin
    rnd_base = r0;
    unique case (state)
      ST_BL1:  rnd_base = h[0];
      ST_BL2:  rnd_base = h[2];
      default: rnd_base = r0;
    endcase
  end

  assign rnd_sum = (PROD_W'(rnd_base) << FRAC_BITS) + $unsigned(prod) +
                   (PROD_W'(1) << (FRAC_BITS - 1));
  assign rnd     = rnd_sum[FRAC_BITS +: DATA_W];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && (func == FUNC_QUERY)) state_next = ST_MAPX;
      ST_MAPX:  state_next = ST_MAPY;
      ST_MAPY:  state_next = ST_CHKY;
      ST_CHKY: begin
        if (bad_cfg || outx || ax_out) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ:  if (slot == 2'd3) state_next = ST_WAITR;
      ST_WAITR: state_next = fail_now ? ST_IDLE : ST_BL0;
      ST_BL0:   state_next = ST_BL1;
      ST_BL1:   state_next = ST_BL2;
      ST_BL2:   state_next = ST_BL3;
      ST_BL3:   state_next = ST_BL4;
      ST_BL4:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      pend  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_READ) begin
        pend <= used;
      end
      if ((state == ST_CHKY) && (bad_cfg || outx || ax_out)) begin
        done <= 1'b1;
      end
      if ((state == ST_WAITR) && fail_now) begin
        done <= 1'b1;
      end
      if (state == ST_BL4) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (accept && (func == FUNC_QUERY)) begin
      dx   <= DIFF_W'(world_x) - DIFF_W'(origin_x);
      dy   <= DIFF_W'(world_y) - DIFF_W'(origin_y);
      fail <= 1'b0;
    end
    if (state == ST_MAPY) begin
      x0   <= ax_cell;
      fx   <= ax_frac;
      outx <= ax_out;
    end
    if (state == ST_CHKY) begin
      y0   <= ax_cell;
      fy   <= ax_frac;
      slot <= 2'd0;
    end
    if (state == ST_READ) begin
      slot      <= slot + 2'd1;
      pend_slot <= slot;
      if (!used) begin
        h[slot] <= '0;
      end
    end
    // Read data lands in the cycle after the address; heights are biased here.
    if (pend) begin
      h[pend_slot] <= ram_rdata[DATA_W-1:0] ^ HEIGHT_BIAS;
      if (!ram_rdata[DATA_W]) begin
        fail <= 1'b1;
      end
    end
    if (state == ST_BL1) begin
      r0 <= rnd;
    end
    if (state == ST_BL2) begin
      r1 <= rnd;
    end
    // Result registers.
    if (state == ST_CHKY) begin
      height <= '0;
      status <= bad_cfg ? STATUS_BAD_CFG : STATUS_OUTSIDE;
    end
    if ((state == ST_WAITR) && fail_now) begin
      height <= '0;
      status <= STATUS_INVALID;
    end
    if (state == ST_BL4) begin
      height <= $signed(rnd ^ HEIGHT_BIAS);
      status <= STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `ASSERT_IMPL(a_ram_write_phase, ram_we, (state == ST_IDLE) || (state == ST_CLEAR),
               "grid RAM written outside the idle or clearing phase")
  `ASSERT_IMPL(a_fail_height_zero, done && (status != STATUS_OK), height == '0,
               "failed query returned a nonzero height")
  `ASSERT_NEXT(a_query_starts, accept && (func == FUNC_QUERY), state == ST_MAPX,
               "accepted query did not enter the mapping phase")
  `ASSERT_NEXT(a_result_frees, done, !busy || (state == ST_MAPX) || (state == ST_IDLE),
               "block not ready after presenting a result")

endmodule
